FILE: hw/rtl/bfws_pkg.sv
// Package for the bounded FIFO with search: sizes, command and status codes,
// payload structs and the controller/datapath link types.
// Depends on nothing; used by every module under hw/rtl.
package bfws_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int CAP_W = 5;
   localparam int CNT_W = 5;
   localparam int WIDE_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
   localparam int DATA_W = 32;

   localparam logic [1:0] CMD_PUSH   = 2'd0;
   localparam logic [1:0] CMD_POP    = 2'd1;
   localparam logic [1:0] CMD_COUNT  = 2'd2;
   localparam logic [1:0] CMD_SEARCH = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef struct packed {
      logic [1:0]               cmd;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data_out;
      logic                     found;
      logic [CNT_W-1:0]         element_count;
      logic [1:0]               status;
   } rsp_type;

   typedef struct packed {
      logic       push_wr;
      logic       rd_head;
      logic       rd_next;
      logic       srch_init;
      logic       pop_commit;
      logic       emit;
      logic       emit_mem_data;
      logic       emit_found;
      logic [1:0] emit_status;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic match;
      logic last;
   } dp_stat_type;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
      logic [IDX_W-1:0] r;
      if (i == IDX_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = i + IDX_W'(1);
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/bfws_ctrl.sv
// Controller for the bounded FIFO with search: sequences push, pop, count
// and the entry-by-entry search. Depends on bfws_pkg.
module bfws_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           cmd,
   input  bfws_pkg::dp_stat_type stat,
   output logic                 busy,
   output bfws_pkg::dp_cmd_type  dp_cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_POP  = 2'd1;
   localparam logic [1:0] S_SRCH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (cmd)
                  bfws_pkg::CMD_PUSH: begin
                     dp_cmd.emit = 1'b1;
                     if (stat.full) begin
                        dp_cmd.emit_status = bfws_pkg::ST_FULL;
                     end else begin
                        dp_cmd.push_wr     = 1'b1;
                        dp_cmd.emit_status = bfws_pkg::ST_OK;
                     end
                  end
                  bfws_pkg::CMD_POP: begin
                     if (stat.empty) begin
                        dp_cmd.emit        = 1'b1;
                        dp_cmd.emit_status = bfws_pkg::ST_EMPTY;
                     end else begin
                        dp_cmd.rd_head = 1'b1;
                        state_in       = S_POP;
                     end
                  end
                  bfws_pkg::CMD_SEARCH: begin
                     if (stat.empty) begin
                        dp_cmd.emit        = 1'b1;
                        dp_cmd.emit_status = bfws_pkg::ST_OK;
                     end else begin
                        dp_cmd.rd_head   = 1'b1;
                        dp_cmd.srch_init = 1'b1;
                        state_in         = S_SRCH;
                     end
                  end
                  default: begin
                     dp_cmd.emit        = 1'b1;
                     dp_cmd.emit_status = bfws_pkg::ST_OK;
                  end
               endcase
            end
         end
         S_POP: begin
            dp_cmd.pop_commit    = 1'b1;
            dp_cmd.emit          = 1'b1;
            dp_cmd.emit_mem_data = 1'b1;
            dp_cmd.emit_status   = bfws_pkg::ST_OK;
            state_in             = S_IDLE;
         end
         S_SRCH: begin
            if (stat.match) begin
               dp_cmd.emit        = 1'b1;
               dp_cmd.emit_found  = 1'b1;
               dp_cmd.emit_status = bfws_pkg::ST_OK;
               state_in           = S_IDLE;
            end else if (stat.last) begin
               dp_cmd.emit        = 1'b1;
               dp_cmd.emit_status = bfws_pkg::ST_OK;
               state_in           = S_IDLE;
            end else begin
               dp_cmd.rd_next = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/bfws_dp.sv
// Datapath for the bounded FIFO with search: entry memory, pointers,
// occupancy, capacity register, search key and the result register.
// Depends on bfws_pkg.
module bfws_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic signed [31:0]        value,
   input  bfws_pkg::dp_cmd_type       dp_cmd,
   input  logic                      cap_wr,
   input  logic [bfws_pkg::CAP_W-1:0] cap_wdata,
   output logic [bfws_pkg::CAP_W-1:0] cap_value,
   output bfws_pkg::dp_stat_type      stat,
   output logic                      rsp_strobe,
   output bfws_pkg::rsp_type          rsp_payload
);

   logic [31:0] mem [bfws_pkg::DEPTH];

   logic [bfws_pkg::IDX_W-1:0] head_ff, head_in;
   logic [bfws_pkg::IDX_W-1:0] tail_ff, tail_in;
   logic [bfws_pkg::IDX_W-1:0] ptr_ff, ptr_in;
   logic [bfws_pkg::OCC_W-1:0] occ_ff, occ_in;
   logic [bfws_pkg::OCC_W-1:0] k_ff, k_in;
   logic [bfws_pkg::CAP_W-1:0] cap_ff;
   logic [31:0]                key_ff;
   logic [31:0]                rd_data_ff;
   logic                       rsp_strobe_ff;
   bfws_pkg::rsp_type          rsp_ff, rsp_in;

   logic                       rd_en;
   logic [bfws_pkg::IDX_W-1:0] rd_addr;
   logic [bfws_pkg::WIDE_W-1:0] occ_wide, cap_wide, cap_eff, occ_in_wide;

   assign rd_en   = dp_cmd.rd_head | dp_cmd.rd_next;
   assign rd_addr = dp_cmd.rd_head ? head_ff : ptr_ff;

   always_ff @(posedge clock) begin
      if (dp_cmd.push_wr) begin
         mem[tail_ff] <= value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign occ_wide = bfws_pkg::WIDE_W'(occ_ff);
   assign cap_wide = bfws_pkg::WIDE_W'(cap_ff);
   assign cap_eff  = (cap_wide > bfws_pkg::WIDE_W'(bfws_pkg::DEPTH)) ?
                     bfws_pkg::WIDE_W'(bfws_pkg::DEPTH) : cap_wide;

   assign stat.full  = (occ_wide >= cap_eff);
   assign stat.empty = (occ_ff == '0);
   assign stat.match = (rd_data_ff == key_ff);
   assign stat.last  = (k_ff == occ_ff);

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      ptr_in  = ptr_ff;
      occ_in  = occ_ff;
      k_in    = k_ff;
      if (dp_cmd.push_wr) begin
         tail_in = bfws_pkg::next_slot(tail_ff);
         occ_in  = occ_ff + bfws_pkg::OCC_W'(1);
      end
      if (dp_cmd.pop_commit) begin
         head_in = bfws_pkg::next_slot(head_ff);
         occ_in  = occ_ff - bfws_pkg::OCC_W'(1);
      end
      if (dp_cmd.srch_init) begin
         ptr_in = bfws_pkg::next_slot(head_ff);
         k_in   = bfws_pkg::OCC_W'(1);
      end
      if (dp_cmd.rd_next) begin
         ptr_in = bfws_pkg::next_slot(ptr_ff);
         k_in   = k_ff + bfws_pkg::OCC_W'(1);
      end
   end

   assign occ_in_wide = bfws_pkg::WIDE_W'(occ_in);

   always_comb begin
      rsp_in               = rsp_ff;
      rsp_in.data_out      = dp_cmd.emit_mem_data ? rd_data_ff : '0;
      rsp_in.found         = dp_cmd.emit_found;
      rsp_in.element_count = occ_in_wide[bfws_pkg::CNT_W-1:0];
      rsp_in.status        = dp_cmd.emit_status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         occ_ff        <= '0;
         ptr_ff        <= '0;
         k_ff          <= '0;
         cap_ff        <= bfws_pkg::CAP_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         occ_ff        <= occ_in;
         ptr_ff        <= ptr_in;
         k_ff          <= k_in;
         rsp_strobe_ff <= dp_cmd.emit;
         if (cap_wr) begin
            cap_ff <= cap_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.srch_init) begin
         key_ff <= value;
      end
      if (dp_cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign cap_value   = cap_ff;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: hw/rtl/bounded_fifo_with_search_unit.sv
// Top level of the bounded FIFO with search: command channel, result strobe
// and APB-style register port. Depends on bfws_pkg, bfws_ctrl and bfws_dp.
//
//   channel   ports                                   handshake
//   request   start, busy, req_payload                start & !busy
//   result    rsp_strobe, rsp_payload                 one-cycle strobe
//   register  psel, penable, pwrite, paddr, pwdata,   psel & penable & pready
//             prdata, pready
//
// Push and count: result in the cycle after the transaction, busy stays low.
// Pop: one memory read, result registered after the S_POP state; an empty pop
//   answers in the cycle after the transaction with busy low.
// Search: one entry of the single memory read port per cycle, up to the
//   occupancy (at most 16) entries; busy is high meanwhile.
// Reset is synchronous; the entry memory is not cleared. Results cannot stall.
module bounded_fifo_with_search_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bfws_pkg::req_type  req_payload,
   output logic              rsp_strobe,
   output bfws_pkg::rsp_type  rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   bfws_pkg::dp_cmd_type       dp_cmd;
   bfws_pkg::dp_stat_type      stat;
   logic                      cap_wr;
   logic [bfws_pkg::CAP_W-1:0] cap_value;

   assign pready = 1'b1;
   assign cap_wr = psel & penable & pwrite & pready & ~paddr[2];
   assign prdata = paddr[2] ? 32'd0 : 32'(cap_value);

   bfws_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .cmd    (req_payload.cmd),
      .stat   (stat),
      .busy   (busy),
      .dp_cmd (dp_cmd)
   );

   bfws_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .value       (req_payload.value),
      .dp_cmd      (dp_cmd),
      .cap_wr      (cap_wr),
      .cap_wdata   (pwdata[bfws_pkg::CAP_W-1:0]),
      .cap_value   (cap_value),
      .stat        (stat),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   a_quick_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_payload.cmd == bfws_pkg::CMD_PUSH ||
                          req_payload.cmd == bfws_pkg::CMD_COUNT)) |=> rsp_strobe)
      else $error("push or count result missing");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.status == bfws_pkg::ST_EMPTY) |->
      (rsp_payload.data_out == 32'sd0 && rsp_payload.found == 1'b0))
      else $error("refused pop carries data");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.found) |->
      (rsp_payload.status == bfws_pkg::ST_OK && rsp_payload.element_count != '0))
      else $error("hit reported with bad status or empty queue");

   a_busy_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.cmd == bfws_pkg::CMD_POP && !rsp_strobe &&
       $past(!busy)) |=> (busy || rsp_strobe))
      else $error("pop neither busy nor answered");

endmodule
